### hw/rtl/stt_pkg.sv
package stt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W    = 4;
  localparam int OWNER_W   = 6;
  localparam int HND_W     = 16;
  localparam int IVAL_W    = 31;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_RM   = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_RM   = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [OWNER_W-1:0] OWNER_ANY  = 6'd32;
  localparam logic [31:0]        DELAY_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic walk;
    logic scan;
    logic fin;
    logic done;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       at_last;
    logic       scan_hold;
    logic       out_free;
  } ctl_sts_t;

endpackage

### hw/rtl/stt_ctrl.sv
module stt_ctrl
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.cmd)
            CMD_ADD, CMD_RM: state_nxt = ST_WALK;
            CMD_SCAN:        state_nxt = ST_SCAN;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.at_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_hold) begin
          cmd.scan = 1'b1;
          if (sts.at_last) state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/stt_dp.sv
module stt_dp
  import stt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic [1:0]          in_cmd,
  input  logic [HND_W-1:0]    in_handler_key,
  input  logic [IVAL_W-1:0]   in_interval_ms,
  input  logic signed [31:0]  in_delay_ms,
  input  logic                in_one_shot,
  input  logic [OWNER_W-1:0]  in_owner_id,
  input  logic [31:0]         in_payload,
  input  logic [31:0]         in_now_ms,
  input  logic [31:0]         in_alive_mask,
  input  ctl_cmd_t            cmd,
  output ctl_sts_t            sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic                out_status,
  output logic [OWNER_W-1:0]  out_receiver,
  output logic [HND_W-1:0]    out_handler_out,
  output logic [31:0]         out_payload_out,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // slot table storage
  logic [HND_W-1:0]   mem_hnd [SLOTS];
  logic [IVAL_W-1:0]  mem_ival[SLOTS];
  logic [31:0]        mem_tick[SLOTS];
  logic               mem_once[SLOTS];
  logic [OWNER_W-1:0] mem_own [SLOTS];
  logic [31:0]        mem_pay [SLOTS];

  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic               enabled_r;

  logic [1:0]         cmd_r;
  logic [HND_W-1:0]   key_r;
  logic [IVAL_W-1:0]  ival_r;
  logic [31:0]        delay_r;
  logic               once_r;
  logic [OWNER_W-1:0] own_r;
  logic [31:0]        pay_r;
  logic [31:0]        now_r;
  logic [31:0]        alive_r;

  logic [IW-1:0]      idx_r, idx_nxt, rd_addr;
  logic [HND_W-1:0]   rd_hnd_r;
  logic [IVAL_W-1:0]  rd_ival_r;
  logic [31:0]        rd_tick_r;
  logic               rd_once_r;
  logic [OWNER_W-1:0] rd_own_r;
  logic [31:0]        rd_pay_r;

  logic               hit_found_r, hit_found_nxt, free_found_r, free_found_nxt;
  logic [IW-1:0]      hit_r, hit_nxt, free_r, free_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic               status_r, status_nxt;
  logic [OWNER_W-1:0] recv_r, recv_nxt;
  logic [HND_W-1:0]   hnd_r, hnd_nxt;
  logic [31:0]        pay_out_r, pay_out_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic               last_r, last_nxt;

  logic               cur_valid, alive_bit, drop, fire, out_free, bad, add_ok;
  logic [31:0]        tick_end;
  logic [IW-1:0]      add_target;

  logic               we_all, we_tick;
  logic [IW-1:0]      waddr;
  logic [31:0]        wtick;

  logic [SLOT_W+IW-1:0] slot_ext;

  assign cur_valid = valid_r[idx_r];
  assign alive_bit = (rd_own_r < OWNER_ANY) && alive_r[rd_own_r[4:0]];
  assign drop      = !alive_bit && (rd_own_r != OWNER_ANY);
  assign tick_end  = rd_tick_r + {1'b0, rd_ival_r};
  assign fire      = (now_r < rd_tick_r) || (now_r > tick_end);
  assign out_free  = !out_valid_r || out_ready;
  assign bad       = !enabled_r || (key_r == '0);
  assign add_ok    = !bad && (hit_found_r || free_found_r);
  assign add_target = hit_found_r ? hit_r : free_r;

  assign sts.cmd       = in_cmd;
  assign sts.at_last   = (idx_r == LAST_IDX);
  assign sts.scan_hold = cur_valid && !drop && fire && !out_free;
  assign sts.out_free  = out_free;

  always_comb begin
    rd_addr = idx_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      rd_addr = '0;
      idx_nxt = '0;
    end else if ((cmd.walk || cmd.scan) && (idx_r != LAST_IDX)) begin
      rd_addr = idx_r + 1'b1;
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    hit_found_nxt  = hit_found_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    valid_nxt      = valid_r;
    we_all         = 1'b0;
    we_tick        = 1'b0;
    waddr          = idx_r;
    wtick          = now_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    recv_nxt       = recv_r;
    hnd_nxt        = hnd_r;
    pay_out_nxt    = pay_out_r;
    slot_nxt       = slot_r;
    last_nxt       = last_r;

    if (cmd.load) begin
      hit_found_nxt  = 1'b0;
      free_found_nxt = 1'b0;
    end

    if (cmd.walk) begin
      if (cur_valid && (rd_hnd_r == key_r) && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_nxt       = idx_r;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_nxt       = idx_r;
      end
    end

    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = (cmd_r == CMD_ADD) ? KIND_ADD : KIND_RM;
      recv_nxt      = '0;
      hnd_nxt       = '0;
      pay_out_nxt   = '0;
      last_nxt      = 1'b1;
      if (cmd_r == CMD_ADD) begin
        status_nxt = !add_ok;
        slot_nxt   = add_ok ? add_target : '0;
        if (add_ok) begin
          we_all              = 1'b1;
          waddr               = add_target;
          wtick               = (delay_r == DELAY_NONE) ? 32'd0 : now_r + delay_r;
          valid_nxt[add_target] = 1'b1;
        end
      end else begin
        status_nxt = bad;
        slot_nxt   = (!bad && hit_found_r) ? hit_r : '0;
        if (!bad && hit_found_r) valid_nxt[hit_r] = 1'b0;
      end
    end

    if (cmd.scan && cur_valid) begin
      if (drop) begin
        valid_nxt[idx_r] = 1'b0;
      end else if (fire) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_FIRE;
        status_nxt    = 1'b0;
        recv_nxt      = rd_own_r;
        hnd_nxt       = rd_hnd_r;
        pay_out_nxt   = rd_pay_r;
        slot_nxt      = idx_r;
        last_nxt      = 1'b0;
        if (rd_once_r) valid_nxt[idx_r] = 1'b0;
        else           we_tick          = 1'b1;
      end
    end

    if (cmd.done) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_DONE;
      status_nxt    = 1'b0;
      recv_nxt      = '0;
      hnd_nxt       = '0;
      pay_out_nxt   = '0;
      slot_nxt      = '0;
      last_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      enabled_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      if (cfg_we) enabled_r <= cfg_wdata;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_handler_key;
      ival_r  <= in_interval_ms;
      delay_r <= in_delay_ms;
      once_r  <= in_one_shot;
      own_r   <= in_owner_id;
      pay_r   <= in_payload;
      now_r   <= in_now_ms;
      alive_r <= in_alive_mask;
    end
    hit_r     <= hit_nxt;
    free_r    <= free_nxt;
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    recv_r    <= recv_nxt;
    hnd_r     <= hnd_nxt;
    pay_out_r <= pay_out_nxt;
    slot_r    <= slot_nxt;
    last_r    <= last_nxt;
  end

  // table write port and registered read port
  always_ff @(posedge clk) begin
    if (we_all) begin
      mem_hnd[waddr]  <= key_r;
      mem_ival[waddr] <= ival_r;
      mem_once[waddr] <= once_r;
      mem_own[waddr]  <= own_r;
      mem_pay[waddr]  <= pay_r;
    end
    if (we_all || we_tick) mem_tick[waddr] <= wtick;
    rd_hnd_r  <= mem_hnd[rd_addr];
    rd_ival_r <= mem_ival[rd_addr];
    rd_tick_r <= mem_tick[rd_addr];
    rd_once_r <= mem_once[rd_addr];
    rd_own_r  <= mem_own[rd_addr];
    rd_pay_r  <= mem_pay[rd_addr];
  end

  assign slot_ext        = {{SLOT_W{1'b0}}, slot_r};
  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_status      = status_r;
  assign out_receiver    = recv_r;
  assign out_handler_out = hnd_r;
  assign out_payload_out = pay_out_r;
  assign out_slot        = slot_ext[SLOT_W-1:0];
  assign out_last        = last_r;

endmodule

### hw/rtl/software_timer_table.sv
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   cmd, key, interval, delay, flags, times, mask
// out_      output     out_valid / out_ready kind, status, receiver, handler, payload, slot
// cfg_      input      cfg_we                enabled
//
// add and remove walk the table one slot per cycle, then the status result
// waits for the output register to empty
// scan visits one slot per cycle, except while a firing slot waits on out_ready
// the walk rate is set by the single registered read port of the slot table
// rst_n is synchronous; it clears slot valid bits, enabled and the controller
// a new transaction is taken while the last result still waits in the output register
module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [HND_W-1:0]    in_handler_key,
  input  logic [IVAL_W-1:0]   in_interval_ms,
  input  logic signed [31:0]  in_delay_ms,
  input  logic                in_one_shot,
  input  logic [OWNER_W-1:0]  in_owner_id,
  input  logic [31:0]         in_payload,
  input  logic [31:0]         in_now_ms,
  input  logic [31:0]         in_alive_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic                out_status,
  output logic [OWNER_W-1:0]  out_receiver,
  output logic [HND_W-1:0]    out_handler_out,
  output logic [31:0]         out_payload_out,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_last
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_handler_key  (in_handler_key),
    .in_interval_ms  (in_interval_ms),
    .in_delay_ms     (in_delay_ms),
    .in_one_shot     (in_one_shot),
    .in_owner_id     (in_owner_id),
    .in_payload      (in_payload),
    .in_now_ms       (in_now_ms),
    .in_alive_mask   (in_alive_mask),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_receiver    (out_receiver),
    .out_handler_out (out_handler_out),
    .out_payload_out (out_payload_out),
    .out_slot        (out_slot),
    .out_last        (out_last)
  );

endmodule
